>>> design/audio_peak_normalizer_macros.svh
// ----------------------------------------------------------------------------
// audio_peak_normalizer assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_PEAK_NORMALIZER_MACROS_SVH
`define AUDIO_PEAK_NORMALIZER_MACROS_SVH

// same-cycle implication
`define APN_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APN_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/apn_pkg.sv
// ----------------------------------------------------------------------------
// apn_pkg
// Types and constants shared by the peak normalizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package apn_pkg;

    localparam int unsigned GAIN_FRAC_BITS_DEF = 16;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MAG_W    = 17;   // holds 32768
    localparam int unsigned GAIN_W   = 32;
    localparam int unsigned BITS_W   = 5;
    localparam int unsigned PCT_W    = 15;
    localparam int unsigned FULL_W   = 15;
    localparam int unsigned DEN_W    = 29;   // 10000 * 32768 fits
    localparam int unsigned CFG_W    = 15;

    localparam int unsigned PCT_SCALE = 10000;

    localparam logic [BITS_W-1:0] BITS_MIN   = 5'd2;
    localparam logic [BITS_W-1:0] BITS_MAX   = 5'd16;
    localparam logic [BITS_W-1:0] BITS_RESET = 5'd16;
    localparam logic [PCT_W-1:0]  PCT_RESET  = 15'd10000;

    localparam logic [SAMPLE_W-1:0] SAT_POS_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG_MIN = 16'h8000;

    // configuration register index
    localparam logic CFG_IDX_BITS = 1'b0;
    localparam logic CFG_IDX_PCT  = 1'b1;

    // request type
    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_SCALE   = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_scaled;
        logic signed [SAMPLE_W-1:0] right_scaled;
    } t_out_item;

    typedef struct packed {
        logic load_in;     // capture accepted beat
        logic meas;        // fold magnitudes into peak
        logic new_clip;    // with meas: start from zero peak
        logic gain_unity;  // gain = 1.0
        logic gain_prep;   // load dividend / divisor
        logic div_step;    // one quotient bit
        logic gain_latch;  // quotient -> gain, saturated
        logic mul_left;
        logic mul_right;   // also loads output register
    } t_cmd;

    typedef struct packed {
        logic peak_zero;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> design/apn_ctrl.sv
// ----------------------------------------------------------------------------
// apn_ctrl
// Sequencer: handshake, clip phase, gain computation and multiply steps.
// ----------------------------------------------------------------------------
`default_nettype none

module apn_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_req_type,
    output logic               o_in_ready,
    input  wire apn_pkg::t_sts i_sts,
    output apn_pkg::t_cmd      o_cmd
);
    import apn_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MEAS  = 7'b0000010,
        S_GPREP = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_GSAT  = 7'b0010000,
        S_MUL_L = 7'b0100000,
        S_MUL_R = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_phase, n_phase;   // 1 = scaling, gain valid for this clip

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_req_type == REQ_MEASURE) begin
                        n_state = S_MEAS;
                    end else if (r_phase) begin
                        n_state = S_MUL_L;
                    end else begin
                        n_state = S_GPREP;
                    end
                end
            end
            S_MEAS: begin
                o_cmd.meas     = 1'b1;
                o_cmd.new_clip = r_phase;
                n_phase        = 1'b0;
                n_state        = S_IDLE;
            end
            S_GPREP: begin
                if (i_sts.peak_zero) begin
                    o_cmd.gain_unity = 1'b1;
                    n_phase          = 1'b1;
                    n_state          = S_MUL_L;
                end else begin
                    o_cmd.gain_prep = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_GSAT;
                end
            end
            S_GSAT: begin
                o_cmd.gain_latch = 1'b1;
                n_phase          = 1'b1;
                n_state          = S_MUL_L;
            end
            S_MUL_L: begin
                o_cmd.mul_left = 1'b1;
                n_state        = S_MUL_R;
            end
            S_MUL_R: begin
                if (i_sts.out_free) begin
                    o_cmd.mul_right = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/apn_dp.sv
// ----------------------------------------------------------------------------
// apn_dp
// Datapath: config registers, peak tracker, restoring gain divider,
// shared sample multiplier with saturation, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module apn_dp #(
    parameter int unsigned GAIN_FRAC_BITS = apn_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [apn_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire apn_pkg::t_in_item          i_in,
    input  wire apn_pkg::t_cmd              i_cmd,
    output apn_pkg::t_sts                   o_sts,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output apn_pkg::t_out_item              o_out
);
    import apn_pkg::*;

    localparam int unsigned FP_W   = FULL_W + PCT_W;
    localparam int unsigned NUM_W  = FP_W + GAIN_FRAC_BITS;
    localparam int unsigned CNT_W  = $clog2(NUM_W);
    localparam int unsigned PROD_W = MAG_W + GAIN_W;

    // config
    logic [BITS_W-1:0] r_bits;
    logic [PCT_W-1:0]  r_pct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= BITS_RESET;
            r_pct  <= PCT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_IDX_BITS) begin
                r_bits <= i_cfg_data[BITS_W-1:0];
            end else begin
                r_pct <= i_cfg_data[PCT_W-1:0];
            end
        end
    end

    // captured beat
    t_in_item r_in;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in;
        end
    end

    function automatic logic [MAG_W-1:0] mag16(logic [SAMPLE_W-1:0] s);
        if (s[SAMPLE_W-1]) begin
            return (MAG_W'(1) << SAMPLE_W) - {1'b0, s};
        end
        return {1'b0, s};
    endfunction

    logic [MAG_W-1:0] mag_l, mag_r;
    assign mag_l = mag16(r_in.left_sample);
    assign mag_r = mag16(r_in.right_sample);

    // peak tracker
    logic [MAG_W-1:0] r_peak;
    logic [MAG_W-1:0] peak_base, peak_lr, peak_nx;

    always_comb begin
        peak_base = i_cmd.new_clip ? '0 : r_peak;
        peak_lr   = (mag_l > mag_r) ? mag_l : mag_r;
        peak_nx   = (peak_lr > peak_base) ? peak_lr : peak_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else if (i_cmd.meas) begin
            r_peak <= peak_nx;
        end
    end

    // gain dividend: full scale * percent, shifted up by fraction bits
    logic [BITS_W-1:0] bits_c;
    logic [FULL_W-1:0] full;
    logic [FP_W-1:0]   full_pct;

    always_comb begin
        if (r_bits < BITS_MIN) begin
            bits_c = BITS_MIN;
        end else if (r_bits > BITS_MAX) begin
            bits_c = BITS_MAX;
        end else begin
            bits_c = r_bits;
        end
        full     = FULL_W'((MAG_W'(1) << (bits_c - BITS_W'(1))) - MAG_W'(1));
        full_pct = FP_W'(full) * FP_W'(r_pct);
    end

    // restoring divider, one quotient bit per cycle, MSB first
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [GAIN_W-1:0] r_q;
    logic              r_ovf;     // quotient bit lost above 32 bits
    logic [CNT_W-1:0]  r_cnt;
    logic [DEN_W:0]    rem_sh, rem_sub;
    logic              q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gain_prep) begin
            r_num <= {full_pct, {GAIN_FRAC_BITS{1'b0}}};
            r_den <= DEN_W'(DEN_W'(r_peak) * DEN_W'(PCT_SCALE));
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= r_num << 1;
            r_rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_q   <= {r_q[GAIN_W-2:0], q_bit};
            r_ovf <= r_ovf | r_q[GAIN_W-1];
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    logic [GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
        end else if (i_cmd.gain_unity) begin
            r_gain <= GAIN_W'(1) << GAIN_FRAC_BITS;
        end else if (i_cmd.gain_latch) begin
            r_gain <= r_ovf ? '1 : r_q;
        end
    end

    // shared multiplier: left then right
    function automatic logic [SAMPLE_W-1:0] sat_out(logic [PROD_W-1:0] pv, logic neg);
        if (neg) begin
            if (pv > PROD_W'(SAT_NEG_MIN)) begin
                return SAT_NEG_MIN;
            end
            return SAMPLE_W'((MAG_W'(1) << SAMPLE_W) - pv[MAG_W-1:0]);
        end
        if (pv > PROD_W'(SAT_POS_MAX)) begin
            return SAT_POS_MAX;
        end
        return pv[SAMPLE_W-1:0];
    endfunction

    logic [MAG_W-1:0]    mul_a;
    logic                mul_neg;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] scaled;

    always_comb begin
        mul_a   = i_cmd.mul_right ? mag_r : mag_l;
        mul_neg = i_cmd.mul_right ? r_in.right_sample[SAMPLE_W-1]
                                  : r_in.left_sample[SAMPLE_W-1];
        prod    = PROD_W'(mul_a) * PROD_W'(r_gain);
        scaled  = sat_out(prod >> GAIN_FRAC_BITS, mul_neg);
    end

    logic [SAMPLE_W-1:0] r_left_res;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_left) begin
            r_left_res <= scaled;
        end
    end

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.mul_right) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_right) begin
            r_out.left_scaled  <= r_left_res;
            r_out.right_scaled <= scaled;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
    assign o_sts.peak_zero = (r_peak == '0);
    assign o_sts.div_last  = (r_cnt == CNT_W'(NUM_W - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

>>> design/audio_peak_normalizer.sv
// ----------------------------------------------------------------------------
// audio_peak_normalizer
// Two-pass stereo peak normalizer: measure pass tracks the peak magnitude,
// scale pass multiplies each frame by a per-clip gain.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                   payload
//  in       in   i_in_valid / o_in_ready     t_in_item  (req_type, left, right)
//  out      out  o_out_valid / i_out_ready   t_out_item (left, right scaled)
//  cfg      in   i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  Measure frame: accept, then peak update; no result beat.
//  Scale frame: accept, left multiply, right multiply into the
//  output register. The first scale frame of a clip adds the gain
//  computation: divider prepare, the bit-serial restoring divider steps, then
//  the saturating gain latch; only a unity-gain load if the peak is zero.
//  Reset is synchronous and needs no clearing pass.
//  A pending result beat stalls only the right-multiply step of the next
//  scale frame; measure frames and gain computation proceed underneath it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_peak_normalizer_macros.svh"

module audio_peak_normalizer #(
    parameter int unsigned GAIN_FRAC_BITS = apn_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // config write port
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_idx,
    input  wire logic [apn_pkg::CFG_W-1:0]  i_cfg_data,
    // input frames
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire apn_pkg::t_in_item          i_in,
    // result frames
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output apn_pkg::t_out_item              o_out
);
    import apn_pkg::*;

    t_cmd w_cmd;   // controller -> datapath
    t_sts w_sts;   // datapath -> controller

    // sequencer: owns the clip phase and steps the datapath
    apn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in.req_type),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: peak, divider, multiplier, output register
    apn_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // one frame in flight: ready drops right after an accepted beat
    `APN_ASSERT_NXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready,
        "input accepted while a frame was still in flight")

    // a result beat only appears from the right-multiply step
    `APN_ASSERT_IMP(a_out_source, $rose(o_out_valid), $past(w_cmd.mul_right),
        "result beat raised without a multiply step")

    // never overwrite a result that has not been taken
    `APN_ASSERT_IMP(a_no_overwrite, w_cmd.mul_right, w_sts.out_free,
        "output register loaded while holding an untaken beat")

endmodule

`default_nettype wire
